[rtl/core/rptfe_pkg.sv]
// package: types, constants and helpers for the radix page table fill engine
package rptfe_pkg;

  localparam int unsigned PoolTablesDef = 64;
  localparam int unsigned Entries       = 512;
  localparam int unsigned Levels        = 4;

  localparam logic [1:0] CmdMap4k  = 2'd0;
  localparam logic [1:0] CmdMap2m  = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;
  localparam logic [1:0] CmdClear  = 2'd3;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StDeclined = 2'd1;
  localparam logic [1:0] StProtect  = 2'd2;

  localparam logic [63:0] ERead  = 64'h1;
  localparam logic [63:0] ERx    = 64'h5;
  localparam logic [63:0] EWrite = 64'h2;
  localparam logic [63:0] ELarge = 64'h80;

  localparam logic [51:0] FrameMask   = 52'hFFFFFFFFFF000;
  localparam logic [51:0] Frame2mMask = 52'hFFFFFFFE00000;

  localparam logic RegPoolBase = 1'b0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] guest_addr;
    logic [51:0] host_addr;
    logic [2:0]  mem_type;
    logic        read_only;
    logic        is_write;
    logic        host_2m_valid;
    logic        type_uniform_2m;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] level;
    logic       tlb_flush;
    logic [6:0] tables_used;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MOVE_RD,
    S_MOVE_CHK,
    S_DECIDE,
    S_ROOT_CLR,
    S_FILL_PTR,
    S_FILL_ZERO,
    S_LEAF,
    S_RESP
  } state_e;

  // 9-bit table index of a guest address at a level (level 1..4)
  function automatic logic [8:0] ga_index(logic [47:0] ga, logic [2:0] lvl);
    logic [47:0] sh;
    sh = ga >> (9 * int'(lvl) + 3);
    return sh[8:0];
  endfunction

endpackage

[rtl/core/rptfe_ram.sv]
// generic single port ram with registered read
module rptfe_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or read one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/core/radix_page_table_fill_engine.sv]
// top level: radix page table fill engine with table store and walk sequencer
// One transaction at a time. A map or query step first climbs the cursor one level per
// cycle. It then walks down, reading one store entry per level in a read state and then a
// check state, for up to three levels below the root. Each newly allocated table takes one
// pointer write, then a pass that zeroes the table one entry per cycle. A clear or a pool
// restart zeroes the root the same way. Every step goes through the single store port.
// The reported level is the cursor level after the walk, or level 3 after a pool restart;
// tables allocated by the fill do not move the cursor. After reset the root is cleared
// in the same zeroing pass before the first transaction.
module radix_page_table_fill_engine #(
  parameter int unsigned PoolTables = rptfe_pkg::PoolTablesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rptfe_pkg::req_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rptfe_pkg::rsp_t  out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int unsigned Depth = (PoolTables + 1) * rptfe_pkg::Entries;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned PW    = $clog2(PoolTables + 1);
  localparam int unsigned CW    = PW + 2;

  rptfe_pkg::state_e state_q, state_d;
  rptfe_pkg::req_t   req_q, req_d;
  rptfe_pkg::rsp_t   rsp_q, rsp_d;
  logic              out_valid_q, out_valid_d;
  logic [51:0]       pool_base_q;
  logic [PW-1:0]     pool_next_q, pool_next_d;
  logic [2:0]        lvl_q, lvl_d;
  logic [47:0]       caddr_q, caddr_d;
  logic [AW-1:0]     centry_q [4];
  logic [AW-1:0]     centry_d [4];
  logic [AW-1:0]     p_q, p_d;
  logic [8:0]        cnt_q, cnt_d;
  logic              flush_q, flush_d;
  logic              init_q, init_d;
  logic [2:0]        tgt_q, tgt_d;
  logic [2:0]        fl_q, fl_d;
  logic [1:0]        status_q, status_d;

  logic              we;
  logic [AW-1:0]     addr;
  logic [63:0]       wdata, rdata;

  rptfe_ram #(.Width(64), .Depth(Depth)) u_store (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // apb register
  assign pready = 1'b1;
  assign prdata = {12'd0, pool_base_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == rptfe_pkg::RegPoolBase) begin
      pool_base_q <= pwdata[51:0];
    end
  end

  // walk decode of the entry just read
  logic [51:0]   diff;
  logic          ptr_ok;
  logic [PW-1:0] pidx;
  logic [47:0]   mmask, mvar;
  logic [CW-1:0] need;
  logic [51:0]   new_tab;
  always_comb begin
    diff   = (rdata[51:0] & rptfe_pkg::FrameMask) - (pool_base_q & rptfe_pkg::FrameMask);
    ptr_ok = rdata[0] && !rdata[7] && (diff[51:12] < 40'(PoolTables));
    pidx   = diff[12 +: PW];
    mvar   = 48'hFFFFFFFFF000 << (9 * int'(lvl_q));
    mmask  = (lvl_q >= 3'd4) ? 48'd0 : mvar;
    need   = CW'(pool_next_q) + CW'(lvl_q) - CW'(tgt_q);
    new_tab = (pool_base_q + {pool_next_q, 12'd0}) & rptfe_pkg::FrameMask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rptfe_pkg::S_ROOT_CLR;
      out_valid_q <= 1'b0;
      pool_next_q <= '0;
      lvl_q       <= 3'd4;
      caddr_q     <= '0;
      cnt_q       <= '0;
      flush_q     <= 1'b0;
      init_q      <= 1'b1;
      for (int i = 0; i < 4; i++) centry_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pool_next_q <= pool_next_d;
      lvl_q       <= lvl_d;
      caddr_q     <= caddr_d;
      cnt_q       <= cnt_d;
      flush_q     <= flush_d;
      init_q      <= init_d;
      for (int i = 0; i < 4; i++) centry_q[i] <= centry_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    rsp_q    <= rsp_d;
    p_q      <= p_d;
    tgt_q    <= tgt_d;
    fl_q     <= fl_d;
    status_q <= status_d;
  end

  assign in_ready_o  = (state_q == rptfe_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // sequencer
  always_comb begin
    state_d = state_q; req_d = req_q; rsp_d = rsp_q; out_valid_d = out_valid_q;
    pool_next_d = pool_next_q; lvl_d = lvl_q; caddr_d = caddr_q;
    for (int i = 0; i < 4; i++) centry_d[i] = centry_q[i];
    p_d = p_q; cnt_d = cnt_q; flush_d = flush_q; init_d = init_q;
    tgt_d = tgt_q; fl_d = fl_q; status_d = status_q;
    we = 1'b0; addr = p_q; wdata = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      rptfe_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i; flush_d = 1'b0; status_d = rptfe_pkg::StDone;
          tgt_d = (in_data_i.cmd == rptfe_pkg::CmdMap2m) ? 3'd1 : 3'd0;
          state_d = rptfe_pkg::S_START;
        end
      end
      rptfe_pkg::S_START: begin
        if (req_q.cmd == rptfe_pkg::CmdClear) begin
          flush_d = 1'b1; pool_next_d = '0; lvl_d = 3'd4; cnt_d = '0;
          state_d = rptfe_pkg::S_ROOT_CLR;
        end else if (req_q.cmd == rptfe_pkg::CmdMap4k && req_q.read_only && req_q.is_write) begin
          status_d = rptfe_pkg::StProtect; state_d = rptfe_pkg::S_RESP;
        end else begin
          // climb while upper bits differ from the cursor address
          caddr_d = req_q.guest_addr;
          if (lvl_q == 3'd0 &&
              (req_q.guest_addr & 48'hFFFFFFFFF000) == (caddr_q & 48'hFFFFFFFFF000)) begin
            state_d = rptfe_pkg::S_DECIDE;
          end else if (lvl_q < 3'd4 && (req_q.guest_addr & mmask) != (caddr_q & mmask)) begin
            lvl_d = lvl_q + 3'd1; caddr_d = caddr_q;
          end else if (lvl_q == 3'd0) begin
            state_d = rptfe_pkg::S_DECIDE;
          end else begin
            if (lvl_q >= 3'd4) begin
              p_d = AW'(rptfe_pkg::ga_index(req_q.guest_addr, 3'd4));
              centry_d[3] = AW'(rptfe_pkg::ga_index(req_q.guest_addr, 3'd4));
              lvl_d = 3'd3;
            end else begin
              p_d = centry_q[lvl_q[1:0]];
            end
            state_d = rptfe_pkg::S_MOVE_RD;
          end
        end
      end
      rptfe_pkg::S_MOVE_RD: begin
        addr = p_q;
        state_d = (lvl_q == 3'd0) ? rptfe_pkg::S_DECIDE : rptfe_pkg::S_MOVE_CHK;
      end
      rptfe_pkg::S_MOVE_CHK: begin
        if (ptr_ok) begin
          p_d = AW'((int'(pidx) + 1) * rptfe_pkg::Entries)
              + AW'(rptfe_pkg::ga_index(req_q.guest_addr, lvl_q));
          centry_d[lvl_q[1:0] - 2'd1] = p_d;
          lvl_d = lvl_q - 3'd1;
          state_d = rptfe_pkg::S_MOVE_RD;
        end else begin
          state_d = rptfe_pkg::S_DECIDE;
        end
      end
      rptfe_pkg::S_DECIDE: begin
        if (req_q.cmd == rptfe_pkg::CmdQuery) begin
          state_d = rptfe_pkg::S_RESP;
        end else if (req_q.cmd == rptfe_pkg::CmdMap2m &&
                     (lvl_q == 3'd0 || !req_q.host_2m_valid || !req_q.type_uniform_2m)) begin
          status_d = rptfe_pkg::StDeclined; state_d = rptfe_pkg::S_RESP;
        end else if (need > CW'(PoolTables)) begin
          flush_d = 1'b1; pool_next_d = '0; lvl_d = 3'd3; fl_d = 3'd3; cnt_d = '0;
          p_d = centry_q[3];
          state_d = rptfe_pkg::S_ROOT_CLR;
        end else begin
          p_d = centry_q[lvl_q[1:0]];
          fl_d = lvl_q;
          state_d = (lvl_q > tgt_q) ? rptfe_pkg::S_FILL_PTR : rptfe_pkg::S_LEAF;
        end
      end
      rptfe_pkg::S_ROOT_CLR: begin
        we = 1'b1; addr = AW'(cnt_q); wdata = '0; cnt_d = cnt_q + 9'd1;
        if (cnt_q == 9'd511) begin
          if (init_q) begin
            init_d = 1'b0; state_d = rptfe_pkg::S_IDLE;
          end else if (req_q.cmd == rptfe_pkg::CmdClear) begin
            state_d = rptfe_pkg::S_RESP;
          end else begin
            p_d = centry_q[3]; state_d = rptfe_pkg::S_FILL_PTR;
          end
        end
      end
      rptfe_pkg::S_FILL_PTR: begin
        we = 1'b1; addr = p_q;
        wdata = {12'd0, new_tab} | rptfe_pkg::ERx | rptfe_pkg::EWrite;
        cnt_d = '0;
        state_d = rptfe_pkg::S_FILL_ZERO;
      end
      rptfe_pkg::S_FILL_ZERO: begin
        // fill level steps down; the cursor itself stays where the walk left it
        we = 1'b1;
        addr = AW'((int'(pool_next_q) + 1) * rptfe_pkg::Entries) + AW'(cnt_q);
        cnt_d = cnt_q + 9'd1;
        if (cnt_q == 9'd511) begin
          p_d = AW'((int'(pool_next_q) + 1) * rptfe_pkg::Entries)
              + AW'(rptfe_pkg::ga_index(req_q.guest_addr, fl_q));
          pool_next_d = pool_next_q + PW'(1);
          fl_d = fl_q - 3'd1;
          state_d = (fl_q - 3'd1 > tgt_q) ? rptfe_pkg::S_FILL_PTR : rptfe_pkg::S_LEAF;
        end
      end
      rptfe_pkg::S_LEAF: begin
        we = 1'b1; addr = p_q;
        if (req_q.cmd == rptfe_pkg::CmdMap2m) begin
          wdata = {12'd0, req_q.host_addr & rptfe_pkg::Frame2mMask}
                | {58'd0, req_q.mem_type, 3'd0}
                | rptfe_pkg::ERx | rptfe_pkg::EWrite | rptfe_pkg::ELarge;
        end else begin
          wdata = {12'd0, req_q.host_addr & rptfe_pkg::FrameMask}
                | {58'd0, req_q.mem_type, 3'd0} | rptfe_pkg::ERx
                | (req_q.read_only ? 64'd0 : rptfe_pkg::EWrite);
        end
        state_d = rptfe_pkg::S_RESP;
      end
      rptfe_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          rsp_d.status = status_q; rsp_d.level = lvl_q; rsp_d.tlb_flush = flush_q;
          rsp_d.tables_used = 7'(pool_next_q);
          out_valid_d = 1'b1;
          state_d = rptfe_pkg::S_IDLE;
        end
      end
      default: state_d = rptfe_pkg::S_IDLE;
    endcase
  end

  // checks
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= 3'd4) else $error("cursor level out of range");
  a_pool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pool_next_q) <= PoolTables) else $error("pool overrun");
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rptfe_pkg::S_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_flush_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == rptfe_pkg::StProtect) |-> !out_data_o.tlb_flush)
    else $error("flush on protected write");

endmodule
